>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: condition does not hold");
// Check that a condition leads to a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
// Check that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/irc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_pkg
// Shared widths, op codes, sequencer states and helpers for the
// reachability/conflict block.
// ----------------------------------------------------------------------------
package irc_pkg;

  localparam int NODE_W    = 6;
  localparam int MAX_NODES = 64;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SUBSET = 2'd0,
    OP_FORBID = 2'd1,
    OP_EQUAL  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_EVAL,
    S_SWEEP,
    S_POST,
    S_CYC_RD,
    S_CYC_CHK,
    S_FINISH
  } state_t;

  // Index of the lowest set bit, found by halving the word six times.
  function automatic logic [NODE_W-1:0] lowest_set(input logic [MAX_NODES-1:0] v);
    logic [MAX_NODES-1:0] x;
    logic [MAX_NODES-1:0] mask;
    logic [NODE_W-1:0]    idx;
    x   = v;
    idx = '0;
    for (int k = NODE_W - 1; k >= 0; k--) begin
      mask = (MAX_NODES'(1) << (1 << k)) - MAX_NODES'(1);
      if ((x & mask) == '0) begin
        idx[k] = 1'b1;
        x      = x >> (1 << k);
      end
    end
    return idx;
  endfunction

endpackage

>>> design/irc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_item_if / irc_result_if
// Valid/ready channels for requests into the block and results out of it.
// ----------------------------------------------------------------------------
interface irc_item_if;
  import irc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;

  modport source (output valid, output op, output first_node, output second_node,
                  input ready);
  modport sink   (input valid, input op, input first_node, input second_node,
                  output ready);
endinterface

interface irc_result_if;
  import irc_pkg::*;

  logic              valid;
  logic              ready;
  logic              changed;
  logic              conflict;
  logic [NODE_W-1:0] conflict_source;
  logic [NODE_W-1:0] conflict_dest;
  logic              cycle;

  modport source (output valid, output changed, output conflict,
                  output conflict_source, output conflict_dest, output cycle,
                  input ready);
  modport sink   (input valid, input changed, input conflict,
                  input conflict_source, input conflict_dest, input cycle,
                  output ready);
endinterface

>>> design/irc_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_row_mem
// One-write, one-read row memory with registered read data. A row valid bit
// per entry makes every row read as zero until it is first written.
// ----------------------------------------------------------------------------
module irc_row_mem #(
  parameter int DEPTH = irc_pkg::MAX_NODES,
  parameter int WIDTH = irc_pkg::MAX_NODES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_vld;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  // Write the row and register the read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Track written rows; reset makes the whole array read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= row_vld[raddr];
      if (we) begin
        row_vld[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

>>> design/incremental_reachability_conflict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_reachability_conflict
// Bit-matrix transitive closure of node reachability with forbidden pairs.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready request {op, first_node, second_node}. op selects a
//            subset edge, a forbidden pair or an equality (edges both ways).
//   result : valid/ready result {changed, conflict, conflict_source,
//            conflict_dest, cycle}, exactly one per request, in order.
//   Paths:   a forbidden pair reads the rows of a and b, then finishes; an
//            ignored request goes straight to the result. A subset edge
//            that is new gets a row sweep, then a check of the cycle flag;
//            an equality inserts both edges in turn. An edge that already
//            exists skips the row sweep. The sweep over every reach row, one
//            row per cycle through the single read port, sets the rate.
//   One request is in flight at a time; the next one is taken as soon as the
//   previous result sits in the output register, even while it waits there.
//   Reset: both matrices read as all zero right away (per-row valid bits),
//   no clearing pass; the result register is emptied.
//   Receiver stall: the finished result holds in the output register and the
//   following request stalls at its last step until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module incremental_reachability_conflict #(
  parameter int NODES = irc_pkg::MAX_NODES
) (
  input  logic         clk,
  input  logic         rst,
  irc_item_if.sink     item,
  irc_result_if.source result
);
  import irc_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam logic [NODE_W:0] NODE_LIMIT = (NODE_W + 1)'(NODES);
  localparam logic [CW-1:0]   ROW_COUNT  = CW'(NODES);

  // Sequencer and request registers
  state_t            state, state_next;
  logic [OP_W-1:0]   op_q;
  logic [NODE_W-1:0] src;
  logic [NODE_W-1:0] dst;
  logic              phase;

  // Row buffers and sweep control
  logic [NODES-1:0]  ra_q;
  logic [NODES-1:0]  fa_q;
  logic [NODES-1:0]  new_row;
  logic [CW-1:0]     rd_idx;
  logic              proc_valid;
  logic [AW-1:0]     proc_row;

  // Running result
  logic              changed_q;
  logic              conflict_q;
  logic [NODE_W-1:0] csrc_q;
  logic [NODE_W-1:0] cdst_q;
  logic              cyc_q;

  // Memory ports
  logic              reach_we;
  logic [AW-1:0]     reach_waddr;
  logic [NODES-1:0]  reach_wdata;
  logic              forbid_we;
  logic [NODES-1:0]  forbid_wdata;
  logic [AW-1:0]     rd_addr;
  logic [NODES-1:0]  reach_rd;
  logic [NODES-1:0]  forbid_rd;

  // Datapath helpers
  logic [AW-1:0]     src_idx;
  logic [AW-1:0]     dst_idx;
  logic [NODES-1:0]  ev_bit;
  logic [NODES-1:0]  ev_new;
  logic [NODES-1:0]  ev_hit;
  logic              ev_known;
  logic              sw_take;
  logic [NODES-1:0]  sw_nb;
  logic [NODES-1:0]  sw_hit;
  logic              in_fire;
  logic              in_range;
  logic              op_known;
  logic              out_load;

  assign src_idx = src[AW-1:0];
  assign dst_idx = dst[AW-1:0];

  irc_row_mem #(.DEPTH(NODES), .WIDTH(NODES)) u_reach (
    .clk   (clk),
    .rst   (rst),
    .we    (reach_we),
    .waddr (reach_waddr),
    .wdata (reach_wdata),
    .raddr (rd_addr),
    .rdata (reach_rd)
  );

  irc_row_mem #(.DEPTH(NODES), .WIDTH(NODES)) u_forbid (
    .clk   (clk),
    .rst   (rst),
    .we    (forbid_we),
    .waddr (src_idx),
    .wdata (forbid_wdata),
    .raddr (rd_addr),
    .rdata (forbid_rd)
  );

  // Decode the request at the input
  assign in_fire  = item.valid && item.ready;
  assign in_range = ({1'b0, item.first_node} < NODE_LIMIT) &&
                    ({1'b0, item.second_node} < NODE_LIMIT);
  assign op_known = (item.op == OP_SUBSET) || (item.op == OP_FORBID) ||
                    (item.op == OP_EQUAL);
  assign out_load = (state == S_FINISH) && (!result.valid || result.ready);

  // Edge insert: row a = old a | new bit | row b; new bits checked against
  // forbid row a, the inserted pair first.
  assign ev_bit   = {{(NODES - 1){1'b0}}, 1'b1} << dst_idx;
  assign ev_known = ra_q[dst_idx];
  assign ev_new   = ra_q | ev_bit | reach_rd;
  assign ev_hit   = reach_rd & ~ra_q & ~ev_bit & fa_q;

  // Sweep: every other row that reaches a takes row a
  assign sw_take = proc_valid && (proc_row != src_idx) && reach_rd[src_idx];
  assign sw_nb   = new_row & ~reach_rd;
  assign sw_hit  = sw_nb & forbid_rd;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (in_range && op_known) ? S_RDA : S_FINISH;
        end
      end
      S_RDA:  state_next = S_RDB;
      S_RDB:  state_next = S_EVAL;
      S_EVAL: begin
        if (op_q == OP_FORBID) begin
          state_next = S_FINISH;
        end else if (ev_known) begin
          state_next = S_POST;
        end else begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if ((rd_idx == ROW_COUNT) && proc_valid) begin
          state_next = S_POST;
        end
      end
      S_POST: begin
        if ((op_q == OP_EQUAL) && !phase) begin
          state_next = S_RDA;
        end else if (op_q == OP_SUBSET) begin
          state_next = S_CYC_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CYC_RD:  state_next = S_CYC_CHK;
      S_CYC_CHK: state_next = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control and handshake outputs
  always_comb begin
    rd_addr      = '0;
    reach_we     = 1'b0;
    reach_waddr  = src_idx;
    reach_wdata  = ev_new;
    forbid_we    = 1'b0;
    forbid_wdata = fa_q | ev_bit;
    item.ready   = (state == S_IDLE);
    case (state)
      S_RDA:    rd_addr = src_idx;
      S_RDB:    rd_addr = dst_idx;
      S_CYC_RD: rd_addr = dst_idx;
      S_EVAL: begin
        if (op_q == OP_FORBID) begin
          forbid_we = !fa_q[dst_idx];
        end else begin
          reach_we = !ev_known;
        end
      end
      S_SWEEP: begin
        rd_addr     = rd_idx[AW-1:0];
        reach_we    = sw_take;
        reach_waddr = proc_row;
        reach_wdata = reach_rd | new_row;
      end
      default: rd_addr = '0;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
      rd_idx     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_q       <= item.op;
            src        <= item.first_node;
            dst        <= item.second_node;
            phase      <= 1'b0;
            changed_q  <= 1'b0;
            conflict_q <= 1'b0;
            csrc_q     <= '0;
            cdst_q     <= '0;
            cyc_q      <= 1'b0;
          end
        end
        S_RDB: begin
          ra_q <= reach_rd;
          fa_q <= forbid_rd;
        end
        S_EVAL: begin
          new_row    <= ev_new;
          rd_idx     <= '0;
          proc_valid <= 1'b0;
          if (op_q == OP_FORBID) begin
            if (!fa_q[dst_idx]) begin
              changed_q <= 1'b1;
              if (ra_q[dst_idx]) begin
                conflict_q <= 1'b1;
                csrc_q     <= src;
                cdst_q     <= dst;
              end
            end
          end else if (!ev_known) begin
            changed_q <= 1'b1;
            if (!conflict_q) begin
              if (fa_q[dst_idx]) begin
                conflict_q <= 1'b1;
                csrc_q     <= src;
                cdst_q     <= dst;
              end else if (ev_hit != '0) begin
                conflict_q <= 1'b1;
                csrc_q     <= src;
                cdst_q     <= lowest_set(MAX_NODES'(ev_hit));
              end
            end
          end
        end
        S_SWEEP: begin
          // Issue the next row read and retire the row read last cycle
          if (rd_idx < ROW_COUNT) begin
            proc_valid <= 1'b1;
            proc_row   <= rd_idx[AW-1:0];
            rd_idx     <= rd_idx + CW'(1);
          end else begin
            proc_valid <= 1'b0;
          end
          if (sw_take && (sw_nb != '0)) begin
            changed_q <= 1'b1;
            if (!conflict_q && (sw_hit != '0)) begin
              conflict_q <= 1'b1;
              csrc_q     <= NODE_W'(proc_row);
              cdst_q     <= lowest_set(MAX_NODES'(sw_hit));
            end
          end
        end
        S_POST: begin
          proc_valid <= 1'b0;
          if ((op_q == OP_EQUAL) && !phase) begin
            phase <= 1'b1;
            src   <= dst;
            dst   <= src;
          end
        end
        S_CYC_CHK: cyc_q <= reach_rd[src_idx];
        default: begin
          proc_valid <= proc_valid;
        end
      endcase
    end
  end

  // Hold the finished result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.changed         <= changed_q;
      result.conflict        <= conflict_q;
      result.conflict_source <= csrc_q;
      result.conflict_dest   <= cdst_q;
      result.cycle           <= cyc_q;
    end
  end

  // Checks
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_fire, state != S_IDLE)
  `ASSERT_IMPLY(a_conflict_has_change, clk, rst, result.valid && result.conflict,
                result.changed)
  `ASSERT_IMPLY(a_sweep_bound, clk, rst, state == S_SWEEP, rd_idx <= ROW_COUNT)
  `ASSERT_IMPLY(a_single_writer, clk, rst, reach_we, !forbid_we)

endmodule
